// File: sv/hvns_pkg.sv
`default_nettype none

package hvns_pkg;

  // Fraction bits kept from the scaled coordinate
  localparam int FRAC_W    = 16;
  // Channels actually computed, and channels on the result port
  localparam int NOISE_CH  = 4;
  localparam int NUM_CH    = 4;
  // Q0.24 noise value width
  localparam int VAL_W     = 24;
  localparam int CFG_IDX_W = 3;

  // Multiply-xor hash constants
  localparam logic [31:0] K_MIX_A = 32'h9E3779B1;
  localparam logic [31:0] K_MIX_B = 32'h85EBCA77;
  localparam logic [31:0] K_MIX_C = 32'hC2B2AE3D;
  localparam logic [31:0] K_MIX_D = 32'h27D4EB2F;
  localparam logic [31:0] K_MIX_E = 32'h165667B1;
  localparam logic [31:0] K_SALT  = 32'h9E3779B9;

  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [FRAC_W-1:0] frac_t;

  // Midpoint of the Q0.24 range: zero displacement
  localparam val_t VAL_MID = val_t'(1) << (VAL_W - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEED    = 3'd0,
    CFG_SCALE   = 3'd1,
    CFG_PERTURB = 3'd2,
    CFG_ELEV    = 3'd3
  } cfg_idx_e;

endpackage

`default_nettype wire

// File: sv/hvns_if.sv
`default_nettype none

// Coordinate request channel
interface hvns_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] world_x;
  logic signed [31:0] world_z;

  modport source (output valid, output world_x, output world_z, input ready);
  modport sink   (input valid, input world_x, input world_z, output ready);
endinterface

// Noise result channel
interface hvns_out_if;
  logic               valid;
  logic               ready;
  logic [23:0]        noise_ch0;
  logic [23:0]        noise_ch1;
  logic [23:0]        noise_ch2;
  logic [23:0]        noise_ch3;
  logic signed [31:0] perturbed_x;
  logic signed [31:0] perturbed_z;
  logic signed [24:0] elevation_offset;

  modport source (output valid, output noise_ch0, output noise_ch1, output noise_ch2,
                  output noise_ch3, output perturbed_x, output perturbed_z,
                  output elevation_offset, input ready);
  modport sink   (input valid, input noise_ch0, input noise_ch1, input noise_ch2,
                  input noise_ch3, input perturbed_x, input perturbed_z,
                  input elevation_offset, output ready);
endinterface

`default_nettype wire

// File: sv/hvns_coord.sv
`default_nettype none

// Cell split and smoothstep: stages 1 to 5
module hvns_coord (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [31:0] wx_i,
  input  wire logic signed [31:0] wz_i,
  input  wire logic [31:0]        scale_i,
  output logic [31:0]             cell_x_o,
  output logic [31:0]             cell_z_o,
  output hvns_pkg::frac_t         sx_o,
  output hvns_pkg::frac_t         sz_o
);
  import hvns_pkg::*;

  localparam logic [FRAC_W+1:0] THREE_ONE = (FRAC_W + 2)'(3) << FRAC_W;

  logic signed [63:0]     prod_q [2];
  frac_t                  f_q    [2];
  frac_t                  q_q    [2];
  frac_t                  s_q    [2];
  frac_t                  sx_q4, sz_q4, sz_q5;
  logic signed [31:0]     w_in   [2];
  logic signed [32:0]     scale_s;
  frac_t                  fr     [2];
  logic [2*FRAC_W-1:0]    tt     [2];
  logic [FRAC_W+1:0]      wt     [2];
  logic [2*FRAC_W+1:0]    qs     [2];

  assign w_in[0] = wx_i;
  assign w_in[1] = wz_i;
  assign scale_s = $signed({1'b0, scale_i});

  // fraction square, then cubic weight
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      fr[a] = prod_q[a][31 -: FRAC_W];
      tt[a] = (2*FRAC_W)'(fr[a]) * (2*FRAC_W)'(fr[a]);
      wt[a] = THREE_ONE - {1'b0, f_q[a], 1'b0};
      qs[a] = (2*FRAC_W+2)'(q_q[a]) * (2*FRAC_W+2)'(wt[a]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < 2; a++) begin
        prod_q[a] <= w_in[a] * scale_s;
        f_q[a]    <= fr[a];
        q_q[a]    <= tt[a][2*FRAC_W-1:FRAC_W];
        s_q[a]    <= qs[a][2*FRAC_W-1:FRAC_W];
      end
      sx_q4 <= s_q[0];
      sz_q4 <= s_q[1];
      sz_q5 <= sz_q4;
    end
  end

  // cell index is the wrapped integer part
  assign cell_x_o = prod_q[0][63:32];
  assign cell_z_o = prod_q[1][63:32];
  assign sx_o     = sx_q4;
  assign sz_o     = sz_q5;

endmodule

`default_nettype wire

// File: sv/hvns_hash.sv
`default_nettype none

// Corner lattice hash: stages 2 to 4
module hvns_hash (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] cell_x_i,
  input  wire logic [31:0] cell_z_i,
  input  wire logic [31:0] salt_mix_i [hvns_pkg::NOISE_CH],
  output hvns_pkg::val_t   corner_o   [hvns_pkg::NOISE_CH][4]
);
  import hvns_pkg::*;

  logic [31:0] ak_q [2];
  logic [31:0] bk_q [2];
  logic [31:0] h1_q [4];
  logic [31:0] h2_q [NOISE_CH][4];
  logic [31:0] h0   [4];
  logic [31:0] g    [NOISE_CH][4];
  logic [31:0] fin  [NOISE_CH][4];

  // corner k: bit 0 selects x+1, bit 1 selects z+1
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      h0[k] = ak_q[k & 1] ^ bk_q[k >> 1];
    end
    for (int c = 0; c < NOISE_CH; c++) begin
      for (int k = 0; k < 4; k++) begin
        g[c][k]        = h1_q[k] ^ salt_mix_i[c];
        fin[c][k]      = h2_q[c][k] ^ (h2_q[c][k] >> 16);
        corner_o[c][k] = fin[c][k][31 -: VAL_W];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ak_q[0] <= cell_x_i * K_MIX_A;
      ak_q[1] <= (cell_x_i + 32'd1) * K_MIX_A;
      bk_q[0] <= cell_z_i * K_MIX_B;
      bk_q[1] <= (cell_z_i + 32'd1) * K_MIX_B;
      for (int k = 0; k < 4; k++) begin
        h1_q[k] <= (h0[k] ^ (h0[k] >> 15)) * K_MIX_C;
      end
      for (int c = 0; c < NOISE_CH; c++) begin
        for (int k = 0; k < 4; k++) begin
          h2_q[c][k] <= (g[c][k] ^ (g[c][k] >> 13)) * K_MIX_E;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/hvns_blend.sv
`default_nettype none

// Bilinear blend: x in stage 5, z in stage 6
module hvns_blend (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire hvns_pkg::val_t  corner_i [hvns_pkg::NOISE_CH][4],
  input  wire hvns_pkg::frac_t sx_i,
  input  wire hvns_pkg::frac_t sz_i,
  output hvns_pkg::val_t       val_o    [hvns_pkg::NOISE_CH]
);
  import hvns_pkg::*;

  val_t top_q [NOISE_CH];
  val_t bot_q [NOISE_CH];
  val_t val_q [NOISE_CH];

  // a + floor((b - a) * w / 2^F), same as the two-term form
  function automatic val_t lerp(val_t a, val_t b, frac_t w);
    logic signed [VAL_W:0]          df;
    logic signed [VAL_W+FRAC_W+1:0] pr;
    logic signed [VAL_W+1:0]        sh;
    df = $signed({1'b0, b}) - $signed({1'b0, a});
    pr = df * $signed({1'b0, w});
    sh = (VAL_W + 2)'(pr >>> FRAC_W);
    return val_t'(sh + $signed({2'b00, a}));
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < NOISE_CH; c++) begin
        top_q[c] <= lerp(corner_i[c][0], corner_i[c][1], sx_i);
        bot_q[c] <= lerp(corner_i[c][2], corner_i[c][3], sx_i);
        val_q[c] <= lerp(top_q[c], bot_q[c], sz_i);
      end
    end
  end

  assign val_o = val_q;

endmodule

`default_nettype wire

// File: sv/hvns_disp.sv
`default_nettype none

// Displacement multiply (stage 7) and saturating add (stage 8)
module hvns_disp (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire hvns_pkg::val_t     n_x_i,
  input  wire hvns_pkg::val_t     n_z_i,
  input  wire hvns_pkg::val_t     n_e_i,
  input  wire hvns_pkg::val_t     pstr_i,
  input  wire hvns_pkg::val_t     estr_i,
  input  wire logic signed [31:0] wx_i,
  input  wire logic signed [31:0] wz_i,
  output logic signed [31:0]      px_o,
  output logic signed [31:0]      pz_o,
  output logic signed [24:0]      elev_o
);
  import hvns_pkg::*;

  logic signed [2*VAL_W+2:0] pr_q [3];
  logic signed [31:0]        w_q  [2];
  logic signed [31:0]        p_q  [2];
  logic signed [VAL_W:0]     e_q;
  logic signed [VAL_W:0]     dd   [3];
  logic signed [33:0]        sum  [2];
  logic signed [31:0]        sat  [2];

  // signed Q1.24 offset from the midpoint times strength
  function automatic logic signed [2*VAL_W+2:0] dmul(val_t n, val_t s);
    logic signed [VAL_W+1:0] d;
    d = $signed({1'b0, n, 1'b0} - {2'b01, {VAL_W{1'b0}}});
    return d * $signed({1'b0, s});
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd[i] = (VAL_W + 1)'(pr_q[i] >>> VAL_W);
    end
    for (int a = 0; a < 2; a++) begin
      sum[a] = 34'(w_q[a]) + 34'(dd[a]);
      if (sum[a][33:31] == 3'b000 || sum[a][33:31] == 3'b111) begin
        sat[a] = sum[a][31:0];
      end else if (sum[a][33]) begin
        sat[a] = 32'sh8000_0000;
      end else begin
        sat[a] = 32'sh7FFF_FFFF;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr_q[0] <= dmul(n_x_i, pstr_i);
      pr_q[1] <= dmul(n_z_i, pstr_i);
      pr_q[2] <= dmul(n_e_i, estr_i);
      w_q[0]  <= wx_i;
      w_q[1]  <= wz_i;
      p_q[0]  <= sat[0];
      p_q[1]  <= sat[1];
      e_q     <= dd[2];
    end
  end

  assign px_o   = p_q[0];
  assign pz_o   = p_q[1];
  assign elev_o = e_q;

endmodule

`default_nettype wire

// File: sv/hashed_value_noise_sampler_unit.sv
// Throughput: one request per cycle; all eight stages advance together and hold
// in place while the result register waits on the sink.
// Reset: rst_ni clears the stage valid bits and loads the register defaults
// (seed 0, scale and both strengths 65536); no clearing pass is needed.
`default_nettype none

module hashed_value_noise_sampler_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [hvns_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [31:0]                      cfg_data_i,
  hvns_in_if.sink                               in_req,
  hvns_out_if.source                            out_res
);
  import hvns_pkg::*;

  // configuration registers
  logic [31:0] seed_q, scale_q;
  val_t        pstr_q, estr_q;
  logic [31:0] salt_q     [NOISE_CH];
  logic [31:0] salt_mix_q [NOISE_CH];

  logic [8:1]         vld_q;
  logic               en;
  logic signed [31:0] wp_q [6][2];
  logic [31:0]        cell_x, cell_z;
  frac_t              sx, sz;
  val_t               corner [NOISE_CH][4];
  val_t               val    [NOISE_CH];
  val_t               full   [NUM_CH];
  val_t               eff    [NUM_CH];
  val_t               nv_q7  [NUM_CH];
  val_t               nv_q8  [NUM_CH];
  logic signed [31:0] px, pz;
  logic signed [24:0] elev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= 32'd0;
      scale_q <= 32'd65536;
      pstr_q  <= val_t'(65536);
      estr_q  <= val_t'(65536);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SEED:    seed_q  <= cfg_data_i;
        CFG_SCALE:   scale_q <= cfg_data_i;
        CFG_PERTURB: pstr_q  <= cfg_data_i[VAL_W-1:0];
        CFG_ELEV:    estr_q  <= cfg_data_i[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // per-channel salt and its hash product, settled long before use
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NOISE_CH; c++) begin
      salt_q[c]     <= seed_q + 32'(c) * K_SALT;
      salt_mix_q[c] <= salt_q[c] * K_MIX_D;
    end
  end

  // whole pipe advances unless the result register is held
  assign en            = !vld_q[8] || out_res.ready;
  assign in_req.ready  = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[7:1], in_req.valid};
    end
  end

  // coordinate carry to the displacement stage
  always_ff @(posedge clk_i) begin
    if (en) begin
      wp_q[0][0] <= in_req.world_x;
      wp_q[0][1] <= in_req.world_z;
      for (int s = 1; s < 6; s++) begin
        wp_q[s] <= wp_q[s-1];
      end
      nv_q7 <= full;
      nv_q8 <= nv_q7;
    end
  end

  hvns_coord u_coord (
    .clk_i    (clk_i),
    .en_i     (en),
    .wx_i     (in_req.world_x),
    .wz_i     (in_req.world_z),
    .scale_i  (scale_q),
    .cell_x_o (cell_x),
    .cell_z_o (cell_z),
    .sx_o     (sx),
    .sz_o     (sz)
  );

  hvns_hash u_hash (
    .clk_i      (clk_i),
    .en_i       (en),
    .cell_x_i   (cell_x),
    .cell_z_i   (cell_z),
    .salt_mix_i (salt_mix_q),
    .corner_o   (corner)
  );

  hvns_blend u_blend (
    .clk_i    (clk_i),
    .en_i     (en),
    .corner_i (corner),
    .sx_i     (sx),
    .sz_i     (sz),
    .val_o    (val)
  );

  // absent channels read zero and displace by nothing
  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    if (c < NOISE_CH) begin : g_on
      assign full[c] = val[c];
      assign eff[c]  = val[c];
    end else begin : g_off
      assign full[c] = '0;
      assign eff[c]  = VAL_MID;
    end
  end

  hvns_disp u_disp (
    .clk_i  (clk_i),
    .en_i   (en),
    .n_x_i  (eff[0]),
    .n_z_i  (eff[2]),
    .n_e_i  (eff[1]),
    .pstr_i (pstr_q),
    .estr_i (estr_q),
    .wx_i   (wp_q[5][0]),
    .wz_i   (wp_q[5][1]),
    .px_o   (px),
    .pz_o   (pz),
    .elev_o (elev)
  );

  assign out_res.valid            = vld_q[8];
  assign out_res.noise_ch0        = nv_q8[0];
  assign out_res.noise_ch1        = nv_q8[1];
  assign out_res.noise_ch2        = nv_q8[2];
  assign out_res.noise_ch3        = nv_q8[3];
  assign out_res.perturbed_x      = px;
  assign out_res.perturbed_z      = pz;
  assign out_res.elevation_offset = elev;

  // accepted request enters stage one
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_req.valid && in_req.ready |=> vld_q[1])
    else $error("accepted request missing from first stage");

  // held result does not move
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[8] && !out_res.ready |=> vld_q[8] && $stable(px) && $stable(elev))
    else $error("stalled result changed");

  // elevation sign follows channel one around its midpoint
  a_elev_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[8] && nv_q8[1][VAL_W-1] |-> !elev[24])
    else $error("elevation negative above midpoint");

  a_elev_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[8] && !nv_q8[1][VAL_W-1] |-> elev[24] || elev == 25'sd0)
    else $error("elevation positive below midpoint");

endmodule

`default_nettype wire

// File: verif/noise_scoreboard.sv
`timescale 1ns / 100ps

// Expected noise results, filled on accepted requests, drained on accepted results
class noise_scoreboard;
  typedef struct packed {
    logic [23:0]        ch0;
    logic [23:0]        ch1;
    logic [23:0]        ch2;
    logic [23:0]        ch3;
    logic signed [31:0] px;
    logic signed [31:0] pz;
    logic signed [24:0] elev;
  } noise_res_t;

  noise_res_t pending_q[$];
  int unsigned mismatches;
  logic [31:0] seed_r;
  logic [31:0] scale_r;
  logic [23:0] perturb_r;
  logic [23:0] elev_r;

  function void reset_regs();
    seed_r    = '0;
    scale_r   = 32'd65536;
    perturb_r = 24'd65536;
    elev_r    = 24'd65536;
  endfunction

  function void write_reg(hvns_pkg::cfg_idx_e idx, logic [31:0] data);
    case (idx)
      hvns_pkg::CFG_SEED:    seed_r = data;
      hvns_pkg::CFG_SCALE:   scale_r = data;
      hvns_pkg::CFG_PERTURB: perturb_r = data[23:0];
      hvns_pkg::CFG_ELEV:    elev_r = data[23:0];
      default: ;
    endcase
  endfunction

  function logic [31:0] lattice_hash(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    logic [31:0] h;
    h = a * hvns_pkg::K_MIX_A;
    h ^= b * hvns_pkg::K_MIX_B;
    h = (h ^ (h >> 15)) * hvns_pkg::K_MIX_C;
    h ^= c * hvns_pkg::K_MIX_D;
    h = (h ^ (h >> 13)) * hvns_pkg::K_MIX_E;
    return h ^ (h >> 16);
  endfunction

  function logic [63:0] smooth(logic [63:0] t);
    logic [63:0] q;
    q = (t * t) >> 16;
    return (q * (3 * 64'd65536 - 2 * t)) >> 16;
  endfunction

  function logic [63:0] lerp(logic [63:0] a, logic [63:0] b, logic [63:0] w);
    return (a * (64'd65536 - w) + b * w) >> 16;
  endfunction

  // floor((2n - 2^24) * s / 2^24)
  function longint displacement(logic [63:0] n, logic [31:0] s);
    logic [63:0] twice;
    twice = 2 * n;
    if (twice >= 64'd16777216) return longint'(((twice - 64'd16777216) * s) >> 24);
    return -longint'((((64'd16777216 - twice) * s) + 64'd16777215) >> 24);
  endfunction

  function logic [31:0] clamp32(longint v);
    if (v > 64'sh7FFFFFFF) return 32'h7FFFFFFF;
    if (v < -64'sh80000000) return 32'h80000000;
    return v[31:0];
  endfunction

  function void note_request(logic signed [31:0] wx, logic signed [31:0] wz);
    logic [63:0] p, fx, fz, tx, tz, top, bot;
    logic [31:0] ix, iz, salt;
    logic [23:0] v[4];
    noise_res_t r;
    p  = 64'(longint'(wx)) * 64'(scale_r);
    ix = p[63:32];
    fx = 64'(p[31:16]);
    p  = 64'(longint'(wz)) * 64'(scale_r);
    iz = p[63:32];
    fz = 64'(p[31:16]);
    tx = smooth(fx);
    tz = smooth(fz);
    for (int c = 0; c < 4; c++) begin
      salt = seed_r + 32'(c) * hvns_pkg::K_SALT;
      top = lerp(64'(lattice_hash(ix, iz, salt) >> 8),
                 64'(lattice_hash(ix + 1, iz, salt) >> 8), tx);
      bot = lerp(64'(lattice_hash(ix, iz + 1, salt) >> 8),
                 64'(lattice_hash(ix + 1, iz + 1, salt) >> 8), tx);
      v[c] = 24'(lerp(top, bot, tz));
    end
    r.ch0  = v[0];
    r.ch1  = v[1];
    r.ch2  = v[2];
    r.ch3  = v[3];
    r.px   = clamp32(longint'(wx) + displacement(64'(v[0]), 32'(perturb_r)));
    r.pz   = clamp32(longint'(wz) + displacement(64'(v[2]), 32'(perturb_r)));
    r.elev = 25'(displacement(64'(v[1]), 32'(elev_r)));
    pending_q.push_back(r);
  endfunction

  function void check_result(noise_res_t got);
    noise_res_t exp_r;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("result with no request pending: %h", got);
      return;
    end
    exp_r = pending_q.pop_front();
    if (got !== exp_r) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: ch %h %h %h %h / %h %h %h %h", exp_r.ch0, exp_r.ch1, exp_r.ch2,
                 exp_r.ch3, got.ch0, got.ch1, got.ch2, got.ch3);
        $display("  pos/elev exp %h %h %h got %h %h %h", exp_r.px, exp_r.pz, exp_r.elev,
                 got.px, got.pz, got.elev);
      end
    end
  endfunction
endclass

// File: verif/tb_hashed_value_noise_sampler_unit.sv
`timescale 1ns / 100ps

module tb_hashed_value_noise_sampler_unit;
  import hvns_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        no_idle;
  int unsigned cycles;

  hvns_in_if  in_req();
  hvns_out_if out_res();
  noise_scoreboard sb;

  hashed_value_noise_sampler_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_req(in_req.sink), .out_res(out_res.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL hashed_value_noise_sampler_unit");
      $finish;
    end
  end

  // Result side: random stall, check on accept
  always @(posedge clk_i) begin
    if (rst_ni && out_res.valid && out_res.ready)
      sb.check_result({out_res.noise_ch0, out_res.noise_ch1, out_res.noise_ch2,
                       out_res.noise_ch3, out_res.perturbed_x, out_res.perturbed_z,
                       out_res.elevation_offset});
    out_res.ready <= no_idle || ($urandom_range(99) >= 32);
  end

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // One request, with random idle cycles ahead of it
  task automatic send_coord(logic [31:0] wx, logic [31:0] wz);
    while (!no_idle && $urandom_range(99) < 32) begin
      in_req.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_req.valid   <= 1'b1;
    in_req.world_x <= wx;
    in_req.world_z <= wz;
    do @(posedge clk_i); while (!in_req.ready);
    sb.note_request(wx, wz);
  endtask

  task automatic drain();
    in_req.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($urandom_range(4096)) << 12 ^ 32'($urandom_range(1) ? 32'hFFF00000 : 0);
      2: return {{8{$urandom_range(1) == 1}}, 24'($urandom())};
      default: return $urandom_range(1) ? 32'h7FFFFFFF - $urandom_range(255)
                                        : 32'h80000000 + $urandom_range(255);
    endcase
  endfunction

  initial begin
    logic [31:0] edge_vals[6];
    sb = new();
    sb.reset_regs();
    no_idle = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_req.valid = 1'b0;
    in_req.world_x = '0;
    in_req.world_z = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: coordinate extremes with default registers
    edge_vals = '{32'h0, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h00010000, 32'h0000FFFF};
    foreach (edge_vals[k]) send_coord(edge_vals[k], edge_vals[5 - k]);
    drain();

    // Zero scale, full strengths: saturation at the range ends
    write_reg(CFG_SCALE, 32'h0);
    write_reg(CFG_PERTURB, 32'hFFFFFF);
    write_reg(CFG_ELEV, 32'hFFFFFF);
    write_reg(CFG_SEED, 32'hFFFFFFFF);
    foreach (edge_vals[k]) send_coord(edge_vals[k], edge_vals[k]);
    drain();

    // Max scale wraps the cell index; zero strengths
    write_reg(CFG_SCALE, 32'hFFFFFFFF);
    write_reg(CFG_PERTURB, 32'h0);
    write_reg(CFG_ELEV, 32'h0);
    foreach (edge_vals[k]) send_coord(edge_vals[k], edge_vals[(k + 2) % 6]);
    drain();

    // Random phases with random registers; one phase without idling
    for (int ph = 0; ph < 8; ph++) begin
      no_idle = (ph == 3);
      write_reg(CFG_SEED, $urandom());
      write_reg(CFG_SCALE, ph[0] ? $urandom() : 32'($urandom_range(1 << 20)));
      write_reg(CFG_PERTURB, $urandom());
      write_reg(CFG_ELEV, $urandom());
      repeat (125) send_coord(rand_coord(), rand_coord());
      drain();
    end

    if (sb.mismatches == 0 && sb.pending_q.size() == 0)
      $display("PASS hashed_value_noise_sampler_unit");
    else
      $display("FAIL hashed_value_noise_sampler_unit");
    $finish;
  end
endmodule
